@@ rtl/rgb_timed_fade_top_defines.svh @@
// ----------------------------------------------------------------------------
// rgb_timed_fade_top_defines.svh
// assertion macros for the rgb timed fade top level
// ----------------------------------------------------------------------------
`ifndef RGB_TIMED_FADE_TOP_DEFINES_SVH
`define RGB_TIMED_FADE_TOP_DEFINES_SVH

// property holds at every clock edge outside reset
`define RTF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define RTF_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/rtf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtf_pkg
// types and constants shared by the rgb timed fade modules
// ----------------------------------------------------------------------------
package rtf_pkg;

   localparam int CHANNELS  = 3;
   localparam int COLOR_W   = 8;
   localparam int TIME_W    = 32;
   localparam int FRAC_W    = 8;
   localparam int DIV_CNT_W = 3;   // counts FRAC_W quotient steps
   localparam int MIX_STEPS = 9;   // bits of f+1
   localparam int MIX_CNT_W = 4;
   localparam int PROD_W    = 16;
   localparam int ADDR_W    = 5;
   localparam int CSR_W     = 32;

   typedef logic [CHANNELS-1:0][COLOR_W-1:0] rgb_type;

   // status of a serial unit
   typedef struct packed {
      logic busy;
      logic done;   // one-cycle pulse, result stays until next start
   } unit_stat_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_PERIOD      = 3'd0,
      REG_START_RED   = 3'd1,
      REG_START_GREEN = 3'd2,
      REG_START_BLUE  = 3'd3,
      REG_STOP_RED    = 3'd4,
      REG_STOP_GREEN  = 3'd5,
      REG_STOP_BLUE   = 3'd6
   } reg_idx_type;

   localparam logic [TIME_W-1:0]  PERIOD_RESET = 32'd1000;
   localparam logic [COLOR_W-1:0] START_RESET  = 8'd0;
   localparam logic [COLOR_W-1:0] STOP_RESET   = 8'd255;

endpackage

@@ rtl/rtf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtf_div
// bit-serial fraction divider: q = floor(num*255/den), one quotient bit a cycle
// ----------------------------------------------------------------------------
module rtf_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                go,
   input  logic [rtf_pkg::TIME_W-1:0]          num,
   input  logic [rtf_pkg::TIME_W-1:0]          den,
   output logic [rtf_pkg::FRAC_W-1:0]          quot,
   output rtf_pkg::unit_stat_type              stat
);

   logic [rtf_pkg::TIME_W-1:0]                 rem_ff, rem_in;
   logic [rtf_pkg::FRAC_W-1:0]                 low_ff, low_in;
   logic [rtf_pkg::FRAC_W-1:0]                 q_ff, q_in;
   logic [rtf_pkg::DIV_CNT_W-1:0]              cnt_ff, cnt_in;
   logic                                       busy_ff, busy_in;
   logic                                       done_ff, done_in;
   logic [rtf_pkg::TIME_W+rtf_pkg::FRAC_W-1:0] scaled;
   logic [rtf_pkg::TIME_W:0]                   trial;
   logic                                       fits;

   // num*255 = (num << 8) - num; num <= den so the quotient fits 8 bits
   assign scaled = {num, rtf_pkg::FRAC_W'(0)} - {rtf_pkg::FRAC_W'(0), num};
   assign trial  = {rem_ff, low_ff[rtf_pkg::FRAC_W-1]};
   // a zero denominator always fits, giving all ones
   assign fits   = (trial >= {1'b0, den});

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         rem_in  = scaled[rtf_pkg::TIME_W+rtf_pkg::FRAC_W-1:rtf_pkg::FRAC_W];
         low_in  = scaled[rtf_pkg::FRAC_W-1:0];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rtf_pkg::TIME_W'(trial - {1'b0, den})
                       : trial[rtf_pkg::TIME_W-1:0];
         low_in = {low_ff[rtf_pkg::FRAC_W-2:0], 1'b0};
         q_in   = {q_ff[rtf_pkg::FRAC_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rtf_pkg::DIV_CNT_W'(rtf_pkg::FRAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
   end

   assign quot      = q_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ rtl/rtf_mix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtf_mix
// bit-serial three-lane color blend: (a*(255-f) + b*(f+1)) >> 8, a when f is 0
// ----------------------------------------------------------------------------
module rtf_mix (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [rtf_pkg::FRAC_W-1:0]  frac,
   input  rtf_pkg::rgb_type            color_a,
   input  rtf_pkg::rgb_type            color_b,
   output rtf_pkg::rgb_type            color,
   output rtf_pkg::unit_stat_type      stat
);

   localparam int CH = rtf_pkg::CHANNELS;
   localparam int PW = rtf_pkg::PROD_W;
   localparam int MS = rtf_pkg::MIX_STEPS;

   logic [MS-1:0]                 g_ff, g_in;   // f + 1, weight of b
   logic [MS-1:0]                 h_ff, h_in;   // 255 - f, weight of a
   logic [CH-1:0][PW-1:0]         ash_ff, ash_in;
   logic [CH-1:0][PW-1:0]         bsh_ff, bsh_in;
   logic [CH-1:0][PW-1:0]         acc_ff, acc_in;
   logic                          zero_ff, zero_in;
   logic [rtf_pkg::MIX_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   always_comb begin
      g_in    = g_ff;
      h_in    = h_ff;
      ash_in  = ash_ff;
      bsh_in  = bsh_ff;
      acc_in  = acc_ff;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         g_in    = MS'(frac) + 1'b1;
         h_in    = {1'b0, ~frac};
         zero_in = (frac == '0);
         cnt_in  = '0;
         busy_in = 1'b1;
         for (int c = 0; c < CH; c++) begin
            ash_in[c] = PW'(color_a[c]);
            bsh_in[c] = PW'(color_b[c]);
            acc_in[c] = '0;
         end
      end else if (busy_ff) begin
         g_in   = g_ff >> 1;
         h_in   = h_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         for (int c = 0; c < CH; c++) begin
            acc_in[c] = acc_ff[c] + (h_ff[0] ? ash_ff[c] : '0)
                                  + (g_ff[0] ? bsh_ff[c] : '0);
            ash_in[c] = ash_ff[c] << 1;
            bsh_in[c] = bsh_ff[c] << 1;
         end
         if (cnt_ff == rtf_pkg::MIX_CNT_W'(MS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      g_ff    <= g_in;
      h_ff    <= h_in;
      ash_ff  <= ash_in;
      bsh_ff  <= bsh_in;
      acc_ff  <= acc_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      for (int c = 0; c < CH; c++) begin
         color[c] = zero_ff ? color_a[c] : acc_ff[c][PW-1:rtf_pkg::COLOR_W];
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ rtl/rgb_timed_fade_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_timed_fade_top
// linear rgb fade from a start color to a stop color over a period in ms
// ----------------------------------------------------------------------------
// Each request carries the free-running millisecond count. The first request
// after reset latches it as the start time and answers with the start color
// and first_tick set. Every later request takes elapsed = now - start (mod
// 2^32), clamps it to fade_period_ms, sets fade_done when the period is
// reached, forms f = elapsed*255/period (255 for a zero period) and blends
// each channel. Done does not latch; only reset restarts the fade. After a
// request is accepted, an 8-step bit-serial divider makes one bit of f per
// cycle, then a 9-step shift-add blender runs the three channels side by
// side; the first request skips the divider. A new request is accepted as
// soon as the response is registered, even if it is not yet taken.
// Registers are written through the csr port at byte address 4*index.
module rgb_timed_fade_top (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,   // [31:0] now_ms
   // response channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata,   // [7:0] red_out, [15:8] green_out,
                                                    // [23:16] blue_out
   output logic [1:0]                  rsp_tuser,   // [0] first_tick, [1] fade_done
   // configuration port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rtf_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [rtf_pkg::CSR_W-1:0]   csr_pwdata,
   output logic [rtf_pkg::CSR_W-1:0]   csr_prdata,
   output logic                        csr_pready
);

`include "rgb_timed_fade_top_defines.svh"

   typedef enum logic [1:0] {
      S_IDLE,   // waiting for a request
      S_DIV,    // divider forms the fraction
      S_MIX,    // blender forms the color
      S_OUT     // waiting for the response register to free up
   } state_type;

   localparam int TW = rtf_pkg::TIME_W;

   // configuration registers
   logic [TW-1:0]                  period_ff;
   rtf_pkg::rgb_type               start_rgb_ff;
   rtf_pkg::rgb_type               stop_rgb_ff;

   // sequencer and datapath registers
   state_type                      state_ff, state_in;
   logic                           started_ff, started_in;
   logic [TW-1:0]                  start_time_ff, start_time_in;
   logic [TW-1:0]                  elapsed_ff, elapsed_in;
   logic                           first_ff, first_in;
   logic                           done_ff, done_in;
   logic [rtf_pkg::FRAC_W-1:0]     frac_ff, frac_in;
   logic                           div_go_ff, div_go_in;
   logic                           mix_go_ff, mix_go_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [23:0]                    rsp_data_ff, rsp_data_in;
   logic [1:0]                     rsp_user_ff, rsp_user_in;

   logic                           req_take;
   logic                           csr_write;
   rtf_pkg::reg_idx_type           csr_idx;
   logic [TW-1:0]                  delta;
   logic                           reached;
   logic [rtf_pkg::FRAC_W-1:0]     div_q;
   rtf_pkg::unit_stat_type         div_stat;
   rtf_pkg::unit_stat_type         mix_stat;
   rtf_pkg::rgb_type               mix_color;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = rtf_pkg::reg_idx_type'(csr_paddr[rtf_pkg::ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= rtf_pkg::PERIOD_RESET;
         start_rgb_ff <= {rtf_pkg::CHANNELS{rtf_pkg::START_RESET}};
         stop_rgb_ff  <= {rtf_pkg::CHANNELS{rtf_pkg::STOP_RESET}};
      end else if (csr_write) begin
         unique case (csr_idx)
            rtf_pkg::REG_PERIOD:      period_ff       <= csr_pwdata;
            rtf_pkg::REG_START_RED:   start_rgb_ff[0] <= csr_pwdata[7:0];
            rtf_pkg::REG_START_GREEN: start_rgb_ff[1] <= csr_pwdata[7:0];
            rtf_pkg::REG_START_BLUE:  start_rgb_ff[2] <= csr_pwdata[7:0];
            rtf_pkg::REG_STOP_RED:    stop_rgb_ff[0]  <= csr_pwdata[7:0];
            rtf_pkg::REG_STOP_GREEN:  stop_rgb_ff[1]  <= csr_pwdata[7:0];
            rtf_pkg::REG_STOP_BLUE:   stop_rgb_ff[2]  <= csr_pwdata[7:0];
            default: ;   // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         rtf_pkg::REG_PERIOD:      csr_prdata = period_ff;
         rtf_pkg::REG_START_RED:   csr_prdata = rtf_pkg::CSR_W'(start_rgb_ff[0]);
         rtf_pkg::REG_START_GREEN: csr_prdata = rtf_pkg::CSR_W'(start_rgb_ff[1]);
         rtf_pkg::REG_START_BLUE:  csr_prdata = rtf_pkg::CSR_W'(start_rgb_ff[2]);
         rtf_pkg::REG_STOP_RED:    csr_prdata = rtf_pkg::CSR_W'(stop_rgb_ff[0]);
         rtf_pkg::REG_STOP_GREEN:  csr_prdata = rtf_pkg::CSR_W'(stop_rgb_ff[1]);
         rtf_pkg::REG_STOP_BLUE:   csr_prdata = rtf_pkg::CSR_W'(stop_rgb_ff[2]);
         default:                  csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   // elapsed time wraps mod 2^32, then clamps to the period
   assign delta   = req_tdata - start_time_ff;
   assign reached = (delta >= period_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;

   rtf_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go_ff),
      .num   (elapsed_ff),
      .den   (period_ff),
      .quot  (div_q),
      .stat  (div_stat)
   );

   rtf_mix u_mix (
      .clock   (clock),
      .reset   (reset),
      .go      (mix_go_ff),
      .frac    (frac_ff),
      .color_a (start_rgb_ff),
      .color_b (stop_rgb_ff),
      .color   (mix_color),
      .stat    (mix_stat)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      started_in    = started_ff;
      start_time_in = start_time_ff;
      elapsed_in    = elapsed_ff;
      first_in      = first_ff;
      done_in       = done_ff;
      frac_in       = frac_ff;
      div_go_in     = 1'b0;
      mix_go_in     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (!started_ff) begin
                  // first request: latch time, blend with f = 0 gives start color
                  started_in    = 1'b1;
                  start_time_in = req_tdata;
                  first_in      = 1'b1;
                  done_in       = 1'b0;
                  frac_in       = '0;
                  mix_go_in     = 1'b1;
                  state_in      = S_MIX;
               end else begin
                  first_in   = 1'b0;
                  done_in    = reached;
                  elapsed_in = reached ? period_ff : delta;
                  div_go_in  = 1'b1;
                  state_in   = S_DIV;
               end
            end
         end
         S_DIV: begin
            // a zero period leaves the divider at all ones, f = 255
            if (div_stat.done) begin
               frac_in   = div_q;
               mix_go_in = 1'b1;
               state_in  = S_MIX;
            end
         end
         S_MIX: begin
            if (mix_stat.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mix_color;
               rsp_user_in  = {done_ff, first_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         started_ff    <= 1'b0;
         start_time_ff <= '0;
         div_go_ff     <= 1'b0;
         mix_go_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         started_ff    <= started_in;
         start_time_ff <= start_time_in;
         div_go_ff     <= div_go_in;
         mix_go_ff     <= mix_go_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      elapsed_ff  <= elapsed_in;
      first_ff    <= first_in;
      done_ff     <= done_in;
      frac_ff     <= frac_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---------------------------------------------------------------- checks
   // any accepted request leaves the fade started
   `RTF_ASSERT_NEXT(a_started_after_req, clock, reset, req_tvalid && req_tready, started_ff, "request accepted but fade not started")
   // the first-tick response never reports done
   `RTF_ASSERT(a_first_not_done, clock, reset, !(rsp_tvalid && rsp_tuser[0] && rsp_tuser[1]), "first tick flagged as done")
   // divider and blender never run together
   `RTF_ASSERT(a_units_exclusive, clock, reset, !(div_stat.busy && mix_stat.busy), "divider and blender busy at once")

endmodule
